// File: sv/matrix_taylor_function_top_defines.svh
// Assertion macros shared by the matrix Taylor-series function RTL.
`ifndef MATRIX_TAYLOR_FUNCTION_TOP_DEFINES_SVH
`define MATRIX_TAYLOR_FUNCTION_TOP_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define MTF_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre.
`define MTF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/mtf_pkg.sv
// Shared types, codes and saturation helper for the matrix Taylor-series block.
package mtf_pkg;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [2:0] {
        MODE_EXP  = 3'd0,
        MODE_COS  = 3'd1,
        MODE_SIN  = 3'd2,
        MODE_COSH = 3'd3,
        MODE_SINH = 3'd4
    } mode_t;

    typedef enum logic {
        CFG_FUNCTION_MODE = 1'b0,
        CFG_MATRIX_SIZE   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_FEED,
        ST_DRAIN,
        ST_SHIFT,
        ST_SCALE,
        ST_OUT_RD,
        ST_OUT_SEND
    } state_t;

    // Term element travelling down the cell row.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               last;
        logic signed [31:0] value;
    } chain_t;

    // Saturated result with its saturation mark.
    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } res_t;

    function automatic res_t sat32(input logic signed [65:0] x);
        res_t r;
        r.sat   = 1'b0;
        r.value = x[31:0];
        if (x > 66'sd2147483647) begin
            r.sat   = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end else if (x < -66'sd2147483648) begin
            r.sat   = 1'b1;
            r.value = 32'sh8000_0000;
        end
        return r;
    endfunction

endpackage

// File: sv/mtf_ram.sv
// Generic simple dual-port RAM with registered read.
module mtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/mtf_cell.sv
// One multiply-accumulate cell: holds a column of A and forms one product element.
module mtf_cell #(
    parameter int MAX_DIM = 8,
    parameter int IDX_W   = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mtf_pkg::chain_t      chain_i,
    output mtf_pkg::chain_t      chain_o,
    input  logic                 a_we,
    input  logic [IDX_W-1:0]     a_addr,
    input  logic signed [31:0]   a_data,
    input  logic                 shift_en,
    input  mtf_pkg::res_t        shift_i,
    output mtf_pkg::res_t        res_o
);
    import mtf_pkg::*;

    localparam int ACC_W = 51;

    logic signed [31:0]      col_reg [MAX_DIM];
    chain_t                  chain_reg;
    logic [IDX_W-1:0]        m_reg;
    logic [IDX_W-1:0]        idx;
    logic signed [63:0]      prod_reg;
    logic                    pv_reg;
    logic                    pf_reg;
    logic                    pl_reg;
    logic signed [63:0]      rnd_full;
    logic signed [47:0]      rnd;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    res_t                    res_reg;

    assign idx      = chain_i.first ? '0 : m_reg;
    assign rnd_full = prod_reg + 64'sd32768;
    assign rnd      = rnd_full[63:16];
    assign acc_next = (pf_reg ? '0 : acc_reg) + {{(ACC_W-48){rnd[47]}}, rnd};

    always_ff @(posedge aclk) begin
        if (a_we) begin
            col_reg[a_addr] <= a_data;
        end
        chain_reg.first <= chain_i.first;
        chain_reg.last  <= chain_i.last;
        chain_reg.value <= chain_i.value;
        prod_reg  <= chain_i.value * col_reg[idx];
        pf_reg    <= chain_i.first;
        pl_reg    <= chain_i.last;
        if (chain_i.valid) begin
            m_reg <= idx + 1'b1;
        end
        if (pv_reg) begin
            acc_reg <= acc_next;
        end
        // Latch the finished dot product, or pass the neighbor's result along.
        if (shift_en) begin
            res_reg <= shift_i;
        end else if (pv_reg && pl_reg) begin
            res_reg <= sat32({{(66-ACC_W){acc_next[ACC_W-1]}}, acc_next});
        end
        if (!aresetn) begin
            chain_reg.valid <= 1'b0;
            pv_reg          <= 1'b0;
        end else begin
            chain_reg.valid <= chain_i.valid;
            pv_reg          <= chain_i.valid;
        end
    end

    assign chain_o = chain_reg;
    assign res_o   = res_reg;
endmodule

// File: sv/matrix_taylor_function_top.sv
// Top level of the matrix Taylor-series function block (exp, cos, sin, cosh, sinh).
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    s_tdata element_value, s_tlast last_element
// m_       out  m_tvalid/m_tready    m_tdata result_value, m_tuser saturated,
//                                    m_tlast last_result
// cfg_     in   cfg_valid/cfg_ready  cfg_index register, cfg_wdata value
//
// Loading accepts one element per cycle. On the completing element the block
// runs K term steps (K = 49 exp, 78 cos/cosh, 79 sin/sinh at default
// parameters); each term step passes through the cell row and then the
// shared scaling unit. Results then leave one at a time, each read from
// the sum RAM before it is offered on m_.
// Reset clears the sequencer, registers and counters; matrix RAMs are not cleared.
// s_tready drops from the completing element until the last result transaction.
`include "matrix_taylor_function_top_defines.svh"

module matrix_taylor_function_top #(
    parameter int MAX_DIM    = 8,
    parameter int EXP_TERMS  = 50,
    parameter int TRIG_TERMS = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [0:0]  m_tuser,   // [0] saturated
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_wdata
);
    import mtf_pkg::*;

    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int AW        = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int KTAB      = (EXP_TERMS > 2 * TRIG_TERMS) ? EXP_TERMS : 2 * TRIG_TERMS;
    localparam int K_W       = $clog2(KTAB);
    localparam int DRAIN_CYC = MAX_DIM + 3;
    localparam int WAIT_W    = $clog2(DRAIN_CYC + 1);

    // Reciprocal factorial steps: round(2^32 / k) as unsigned Q1.32.
    logic [32:0] recip_tab [KTAB];
    for (genvar g = 0; g < KTAB; g++) begin : g_recip
        localparam logic [63:0] KD = (g == 0) ? 64'd1 : 64'(g);
        localparam logic [32:0] RV = 33'(((64'd1 << 32) + KD / 2) / KD);
        assign recip_tab[g] = RV;
    end

    state_t             state_reg, state_next;
    logic [2:0]         function_mode_reg;
    logic [3:0]         matrix_size_reg;
    logic [DIM_W-1:0]   n_now;
    logic [CNT_W-1:0]   cells_now;
    mode_t              mode_now;
    logic [K_W-1:0]     kmax_now;

    logic [CNT_W-1:0]   load_cnt_reg;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W-1:0]   count_reg;
    logic [DIM_W-1:0]   n_reg;
    logic [CNT_W-1:0]   cells_reg;
    mode_t              mode_reg;
    logic [K_W-1:0]     kmax_reg;
    logic [K_W-1:0]     k_reg;
    logic               sat_reg;

    logic [CNT_W-1:0]   c_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;
    logic [CNT_W-1:0]   base_reg;
    logic [WAIT_W-1:0]  wait_reg;
    logic               col_last;
    logic               row_last;
    logic [CNT_W-1:0]   rc_addr;

    logic               in_fire;
    logic               m_fire;
    logic               load_done;
    logic               init_issue;
    logic               scale_issue;
    logic               scale_idle;

    logic               p1_v_reg;
    logic [AW-1:0]      p1_c_reg;
    logic [IDX_W-1:0]   p1_row_reg;
    logic [IDX_W-1:0]   p1_col_reg;
    logic               p1_zero_reg;
    logic               p1_diag;

    logic               f_v_reg;
    logic               f_first_reg;
    logic               f_last_reg;

    logic               s1_v_reg;
    logic [AW-1:0]      s1_c_reg;
    logic               s2_v_reg;
    logic [AW-1:0]      s2_c_reg;
    logic signed [65:0] s2_p_reg;
    logic signed [31:0] s2_sum_reg;
    logic               s3_v_reg;
    logic [AW-1:0]      s3_c_reg;
    logic signed [31:0] s3_t_reg;
    logic signed [31:0] s3_sum_reg;
    logic signed [65:0] s2_rnd;
    res_t               term_res;
    res_t               sum_res;
    logic               use_k;
    logic               neg_k;
    logic               use_zero;

    logic               in_we;
    logic [31:0]        in_rdata;
    logic               term_we;
    logic [AW-1:0]      term_waddr;
    logic [31:0]        term_wdata;
    logic [31:0]        term_rdata;
    logic               sum_we;
    logic [AW-1:0]      sum_waddr;
    logic [31:0]        sum_wdata;
    logic [31:0]        sum_rdata;
    logic               prod_we;
    logic [31:0]        prod_rdata;

    chain_t             chain [MAX_DIM+1];
    res_t               res   [MAX_DIM+1];
    logic signed [31:0] a_data;

    function automatic logic term_used(input mode_t m, input logic k0);
        logic u;
        unique case (m) inside
            MODE_EXP:             u = 1'b1;
            MODE_COS, MODE_COSH:  u = !k0;
            default:              u = k0;
        endcase
        return u;
    endfunction

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            function_mode_reg <= 3'd0;
            matrix_size_reg   <= 4'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FUNCTION_MODE: function_mode_reg <= cfg_wdata[2:0];
                CFG_MATRIX_SIZE:   matrix_size_reg   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Clamp the size and fold undefined modes onto exp.
    always_comb begin
        if (matrix_size_reg == 4'd0) begin
            n_now = DIM_W'(1);
        end else if (matrix_size_reg > 4'(MAX_DIM)) begin
            n_now = DIM_W'(MAX_DIM);
        end else begin
            n_now = DIM_W'(matrix_size_reg);
        end
        cells_now = CNT_W'(n_now) * CNT_W'(n_now);
        mode_now  = (function_mode_reg > 3'd4) ? MODE_EXP : mode_t'(function_mode_reg);
        unique case (mode_now) inside
            MODE_EXP:            kmax_now = K_W'(EXP_TERMS - 1);
            MODE_COS, MODE_COSH: kmax_now = K_W'(2 * (TRIG_TERMS - 1));
            default:             kmax_now = K_W'(2 * TRIG_TERMS - 1);
        endcase
    end

    // ------------------------------------------------------------ handshakes
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT_SEND);
    assign m_fire    = m_tvalid && m_tready;
    assign m_tdata   = sum_rdata;
    assign m_tuser   = sat_reg;
    assign m_tlast   = (c_reg == cells_reg - 1'b1);

    assign cnt_inc     = load_cnt_reg + 1'b1;
    assign load_done   = s_tlast || (cnt_inc >= cells_now);
    assign col_last    = (DIM_W'(col_reg) == n_reg - 1'b1);
    assign row_last    = (DIM_W'(row_reg) == n_reg - 1'b1);
    assign rc_addr     = base_reg + CNT_W'(col_reg);
    assign init_issue  = (state_reg == ST_INIT) && (c_reg != cells_reg);
    assign scale_issue = (state_reg == ST_SCALE) && (c_reg != cells_reg);
    assign scale_idle  = !s1_v_reg && !s2_v_reg && !s3_v_reg;

    // ------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire && load_done) state_next = ST_INIT;
            end
            ST_INIT: begin
                if (c_reg == cells_reg && !p1_v_reg) state_next = ST_FEED;
            end
            ST_FEED: begin
                if (col_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (wait_reg == WAIT_W'(DRAIN_CYC - 1)) state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (col_last) state_next = row_last ? ST_SCALE : ST_FEED;
            end
            ST_SCALE: begin
                if (c_reg == cells_reg && scale_idle) begin
                    state_next = (k_reg == kmax_reg) ? ST_OUT_RD : ST_FEED;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND: begin
                if (m_fire) state_next = m_tlast ? ST_LOAD : ST_OUT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------- sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            sat_reg      <= 1'b0;
            p1_v_reg     <= 1'b0;
            f_v_reg      <= 1'b0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            c_reg        <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            wait_reg     <= '0;
            k_reg        <= '0;
            n_reg        <= DIM_W'(1);
            cells_reg    <= CNT_W'(1);
            count_reg    <= '0;
            kmax_reg     <= '0;
            mode_reg     <= MODE_EXP;
        end else begin
            p1_v_reg <= init_issue;
            f_v_reg  <= (state_reg == ST_FEED);
            s1_v_reg <= scale_issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;

            unique case (state_reg)
                ST_LOAD: begin
                    if (in_fire) begin
                        load_cnt_reg <= load_done ? '0 : cnt_inc;
                        if (load_done) begin
                            // Sample the registers and start the series.
                            count_reg <= cnt_inc;
                            n_reg     <= n_now;
                            cells_reg <= cells_now;
                            mode_reg  <= mode_now;
                            kmax_reg  <= kmax_now;
                            sat_reg   <= 1'b0;
                            c_reg     <= '0;
                            row_reg   <= '0;
                            col_reg   <= '0;
                        end
                    end
                end
                ST_INIT: begin
                    if (init_issue) begin
                        c_reg <= c_reg + 1'b1;
                        if (col_last) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end
                    if (state_next == ST_FEED) begin
                        k_reg    <= K_W'(1);
                        row_reg  <= '0;
                        col_reg  <= '0;
                        base_reg <= '0;
                    end
                end
                ST_FEED: begin
                    col_reg  <= col_last ? '0 : col_reg + 1'b1;
                    wait_reg <= '0;
                end
                ST_DRAIN: begin
                    wait_reg <= wait_reg + 1'b1;
                end
                ST_SHIFT: begin
                    sat_reg <= sat_reg | res[0].sat;
                    if (col_last) begin
                        col_reg  <= '0;
                        row_reg  <= row_last ? '0 : row_reg + 1'b1;
                        base_reg <= row_last ? '0 : base_reg + CNT_W'(n_reg);
                        c_reg    <= '0;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                ST_SCALE: begin
                    if (scale_issue) begin
                        c_reg <= c_reg + 1'b1;
                    end
                    // Collect saturation from the scaling and the sum update.
                    sat_reg <= sat_reg | (s2_v_reg && term_res.sat)
                                       | (s3_v_reg && use_k && sum_res.sat);
                    if (c_reg == cells_reg && scale_idle) begin
                        c_reg <= '0;
                        if (k_reg != kmax_reg) begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                ST_OUT_RD: begin
                end
                ST_OUT_SEND: begin
                    if (m_fire) begin
                        c_reg <= m_tlast ? '0 : c_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload pipeline registers.
    always_ff @(posedge aclk) begin
        p1_c_reg    <= c_reg[AW-1:0];
        p1_row_reg  <= row_reg;
        p1_col_reg  <= col_reg;
        p1_zero_reg <= (c_reg >= count_reg);
        f_first_reg <= (col_reg == '0);
        f_last_reg  <= col_last;
        s1_c_reg    <= c_reg[AW-1:0];
        s2_c_reg    <= s1_c_reg;
        s2_p_reg    <= $signed(prod_rdata) * $signed({1'b0, recip_tab[k_reg]});
        s2_sum_reg  <= sum_rdata;
        s3_c_reg    <= s2_c_reg;
        s3_t_reg    <= term_res.value;
        s3_sum_reg  <= s2_sum_reg;
    end

    // Scale by 1/k with rounding, then add or subtract the term into the sum.
    assign s2_rnd   = s2_p_reg + 66'sd2147483648;
    assign term_res = sat32(s2_rnd >>> 32);
    assign use_k    = term_used(mode_reg, k_reg[0]);
    assign neg_k    = ((mode_reg == MODE_COS) || (mode_reg == MODE_SIN)) && k_reg[1];
    assign use_zero = term_used(mode_reg, 1'b0);
    assign sum_res  = neg_k ? sat32(66'(s3_sum_reg) - 66'(s3_t_reg))
                            : sat32(66'(s3_sum_reg) + 66'(s3_t_reg));
    assign p1_diag  = (p1_row_reg == p1_col_reg);

    // ------------------------------------------------------- memories
    assign in_we      = in_fire;
    assign term_we    = p1_v_reg || s2_v_reg;
    assign term_waddr = p1_v_reg ? p1_c_reg : s2_c_reg;
    assign term_wdata = p1_v_reg ? (p1_diag ? Q_ONE : 32'sd0) : term_res.value;
    assign sum_we     = p1_v_reg || (s3_v_reg && use_k);
    assign sum_waddr  = p1_v_reg ? p1_c_reg : s3_c_reg;
    assign sum_wdata  = p1_v_reg ? ((p1_diag && use_zero) ? Q_ONE : 32'sd0) : sum_res.value;
    assign prod_we    = (state_reg == ST_SHIFT);

    mtf_ram #(.WIDTH(32), .DEPTH(CELLS)) u_input_ram (
        .aclk  (aclk),
        .we    (in_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (c_reg[AW-1:0]),
        .rdata (in_rdata)
    );

    mtf_ram #(.WIDTH(32), .DEPTH(CELLS)) u_term_ram (
        .aclk  (aclk),
        .we    (term_we),
        .waddr (term_waddr),
        .wdata (term_wdata),
        .raddr (rc_addr[AW-1:0]),
        .rdata (term_rdata)
    );

    mtf_ram #(.WIDTH(32), .DEPTH(CELLS)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (c_reg[AW-1:0]),
        .rdata (sum_rdata)
    );

    mtf_ram #(.WIDTH(32), .DEPTH(CELLS)) u_prod_ram (
        .aclk  (aclk),
        .we    (prod_we),
        .waddr (rc_addr[AW-1:0]),
        .wdata (res[0].value),
        .raddr (c_reg[AW-1:0]),
        .rdata (prod_rdata)
    );

    // ------------------------------------------------------- cell row
    // Term row elements enter cell 0 and hop one cell per cycle; cell j
    // multiplies against column j of A. Results drain toward cell 0.
    assign chain[0].valid = f_v_reg;
    assign chain[0].first = f_first_reg;
    assign chain[0].last  = f_last_reg;
    assign chain[0].value = term_rdata;
    assign res[MAX_DIM]   = '0;
    assign a_data         = p1_zero_reg ? 32'sd0 : in_rdata;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mtf_cell #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .chain_i  (chain[g]),
            .chain_o  (chain[g+1]),
            .a_we     (p1_v_reg && (p1_col_reg == IDX_W'(g))),
            .a_addr   (p1_row_reg),
            .a_data   (a_data),
            .shift_en (prod_we),
            .shift_i  (res[g+1]),
            .res_o    (res[g])
        );
    end

    // ------------------------------------------------------- checks
    `MTF_ASSERT_SAME(a_sides_apart, s_tready, !m_tvalid, "input and output open together")
    `MTF_ASSERT_NEXT(a_last_ends, m_fire && m_tlast, state_reg == ST_LOAD,
        "load not resumed after last result")
    `MTF_ASSERT_SAME(a_k_range, state_reg == ST_SCALE, (k_reg != '0) && (k_reg <= kmax_reg),
        "term index out of range")
    `MTF_ASSERT_SAME(a_feed_range, state_reg == ST_FEED, DIM_W'(col_reg) < n_reg,
        "feed index beyond matrix size")

endmodule
